// ----- rtl/core/esm_pkg.sv -----
// Shared constants and types for the EVM squared meter.
`default_nettype none
package esm_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int COUNT_BITS  = 16;
  localparam int CUT_W       = 15;
  localparam int SPM_W       = 16;
  localparam int CFG_W       = 16;
  localparam int CFG_IDX_W   = 1;
  localparam int SUM_W       = 52;
  localparam int RATIO_W     = 32;
  localparam int FRAC_BITS   = 16;

  // difference of two samples and the sum of two squares
  localparam int DIFF_W = SAMPLE_BITS + 1;
  localparam int PROD_W = 2 * DIFF_W;
  localparam int TERM_W = 2 * SAMPLE_BITS + 1;

  // compare width for position, cut and mode length
  localparam int CMP_W = ((COUNT_BITS > SPM_W) ? COUNT_BITS : SPM_W) + 2;

  // queue between accumulator and divider
  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam int STEP_W = $clog2(RATIO_W);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CUT = 1'b0,
    REG_SPM = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic [SUM_W-1:0] err;
    logic [SUM_W-1:0] pwr;
  } sums_t;

endpackage
`default_nettype wire

// ----- rtl/core/esm_front.sv -----
// Front end: position tracking, sample classification, squaring and accumulation.
`default_nettype none
module esm_front import esm_pkg::*; (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_we,
  input  wire logic [CFG_IDX_W-1:0]          cfg_idx,
  input  wire logic [CFG_W-1:0]              cfg_data,
  input  wire logic                          in_push,
  output logic                               in_full,
  input  wire logic signed [SAMPLE_BITS-1:0] in_ref_re,
  input  wire logic signed [SAMPLE_BITS-1:0] in_ref_im,
  input  wire logic signed [SAMPLE_BITS-1:0] in_rcv_re,
  input  wire logic signed [SAMPLE_BITS-1:0] in_rcv_im,
  input  wire logic                          in_frame_end,
  input  wire logic [QCNT_W-1:0]             q_count,
  output logic                               q_push,
  output sums_t                              q_data
);

  logic [CUT_W-1:0]      cut_r;
  logic [SPM_W-1:0]      spm_r;
  logic [COUNT_BITS-1:0] pos_r, pos_nxt;

  logic                          s1_v_r, s1_keep_r, s1_last_r;
  logic signed [SAMPLE_BITS-1:0] s1_tr_r, s1_ti_r, s1_rr_r, s1_ri_r;

  logic              s2_v_r, s2_last_r;
  logic [TERM_W-1:0] s2_err_r, s2_pwr_r;

  logic [SUM_W-1:0] err_acc_r, pwr_acc_r;

  logic             accept;
  logic [CMP_W-1:0] spm_ext, pos_ext, cut_ext, pos_inc;
  logic             keep, wrap;
  logic [1:0]       inflight;
  logic [QCNT_W+1:0] credits;

  logic signed [DIFF_W-1:0] d_re, d_im, t_re, t_im;
  logic signed [PROD_W-1:0] p_dre, p_dim, p_tre, p_tim;
  logic [TERM_W-1:0]        err_term, pwr_term;

  logic [SUM_W:0]   err_add, pwr_add;
  logic [SUM_W-1:0] err_new, pwr_new;

  // hold back new samples while every queue slot is spoken for
  assign inflight = {1'b0, s1_v_r & s1_last_r} + {1'b0, s2_v_r & s2_last_r};
  assign credits  = (QCNT_W+2)'(q_count) + (QCNT_W+2)'(inflight);
  assign in_full  = credits >= (QCNT_W+2)'(QDEPTH);
  assign accept   = in_push && !in_full;

  // mode length zero acts as 2**SPM_W
  assign spm_ext = (spm_r == '0) ? (CMP_W'(1) << SPM_W) : CMP_W'(spm_r);
  assign pos_ext = CMP_W'(pos_r);
  assign cut_ext = CMP_W'(cut_r);
  assign keep    = (pos_ext >= cut_ext) && ((pos_ext + cut_ext) < spm_ext);
  assign pos_inc = pos_ext + CMP_W'(1);
  assign wrap    = (pos_inc >= spm_ext) || (pos_inc >= (CMP_W'(1) << COUNT_BITS));

  always_comb begin
    pos_nxt = pos_r;
    if (accept) begin
      if (in_frame_end || wrap) begin
        pos_nxt = '0;
      end else begin
        pos_nxt = pos_inc[COUNT_BITS-1:0];
      end
    end
  end

  // squares of error and reference
  assign d_re  = DIFF_W'(s1_tr_r) - DIFF_W'(s1_rr_r);
  assign d_im  = DIFF_W'(s1_ti_r) - DIFF_W'(s1_ri_r);
  assign t_re  = DIFF_W'(s1_tr_r);
  assign t_im  = DIFF_W'(s1_ti_r);
  assign p_dre = PROD_W'(d_re) * PROD_W'(d_re);
  assign p_dim = PROD_W'(d_im) * PROD_W'(d_im);
  assign p_tre = PROD_W'(t_re) * PROD_W'(t_re);
  assign p_tim = PROD_W'(t_im) * PROD_W'(t_im);
  assign err_term = s1_keep_r ? (p_dre[TERM_W-1:0] + p_dim[TERM_W-1:0]) : '0;
  assign pwr_term = s1_keep_r ? (p_tre[TERM_W-1:0] + p_tim[TERM_W-1:0]) : '0;

  // saturating accumulate: the limit is all ones, so clamp on carry
  assign err_add = {1'b0, err_acc_r} + (SUM_W+1)'(s2_err_r);
  assign pwr_add = {1'b0, pwr_acc_r} + (SUM_W+1)'(s2_pwr_r);
  assign err_new = err_add[SUM_W] ? '1 : err_add[SUM_W-1:0];
  assign pwr_new = pwr_add[SUM_W] ? '1 : pwr_add[SUM_W-1:0];

  assign q_push     = s2_v_r && s2_last_r;
  assign q_data.err = err_new;
  assign q_data.pwr = pwr_new;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cut_r     <= '0;
      spm_r     <= '1;
      pos_r     <= '0;
      s1_v_r    <= 1'b0;
      s2_v_r    <= 1'b0;
      err_acc_r <= '0;
      pwr_acc_r <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_reg_t'(cfg_idx))
          REG_CUT: cut_r <= cfg_data[CUT_W-1:0];
          REG_SPM: spm_r <= cfg_data[SPM_W-1:0];
          default: ;
        endcase
      end
      pos_r  <= pos_nxt;
      s1_v_r <= accept;
      s2_v_r <= s1_v_r;
      if (s2_v_r) begin
        // clear the sums once a frame's totals leave for the queue
        err_acc_r <= s2_last_r ? '0 : err_new;
        pwr_acc_r <= s2_last_r ? '0 : pwr_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_keep_r <= keep;
      s1_last_r <= in_frame_end;
      s1_tr_r   <= in_ref_re;
      s1_ti_r   <= in_ref_im;
      s1_rr_r   <= in_rcv_re;
      s1_ri_r   <= in_rcv_im;
    end
    if (s1_v_r) begin
      s2_last_r <= s1_last_r;
      s2_err_r  <= err_term;
      s2_pwr_r  <= pwr_term;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/esm_fifo.sv -----
// Short queue of frame totals between accumulator and divider.
`default_nettype none
module esm_fifo import esm_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire sums_t             din,
  input  wire logic              pop,
  output sums_t                  dout,
  output logic                   empty,
  output logic [QCNT_W-1:0]      count
);

  sums_t             mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] count_r;

  function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
    ptr_inc = (p == QPTR_W'(QDEPTH - 1)) ? '0 : p + QPTR_W'(1);
  endfunction

  assign dout  = mem_r[rd_ptr_r];
  assign empty = (count_r == '0);
  assign count = count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      end
      if (pop) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
      if (push && !pop) begin
        count_r <= count_r + QCNT_W'(1);
      end else if (pop && !push) begin
        count_r <= count_r - QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (count_r != QCNT_W'(QDEPTH)))
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty)
    else $error("queue read while empty");

endmodule
`default_nettype wire

// ----- rtl/core/esm_back.sv -----
// Back end: bit-serial ratio divider with saturation and zero-power flags, result register.
`default_nettype none
module esm_back import esm_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                q_empty,
  input  wire sums_t               q_data,
  output logic                     q_pop,
  output logic                     out_empty,
  input  wire logic                out_pop,
  output logic [RATIO_W-1:0]       out_evm_ratio,
  output logic                     out_ratio_saturated,
  output logic                     out_zero_power
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_HOLD
  } state_t;

  state_t             state_r, state_nxt;
  logic [SUM_W-1:0]   pwr_r, pwr_nxt;
  logic [SUM_W-1:0]   rem_r, rem_nxt;
  logic [RATIO_W-1:0] quo_r, quo_nxt;
  logic [STEP_W-1:0]  step_r, step_nxt;
  logic               sat_r, sat_nxt, zero_r, zero_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [RATIO_W-1:0] out_ratio_r, out_ratio_nxt;
  logic               out_sat_r, out_sat_nxt, out_zero_r, out_zero_nxt;

  logic [SUM_W-1:0] err_hi, err_sh;
  logic             is_zero, is_sat;
  logic [SUM_W:0]   trial, diff;
  logic             ge;

  // quotient has RATIO_W bits, so the first partial remainder is err >> 16
  assign err_hi  = q_data.err >> (RATIO_W - FRAC_BITS);
  assign err_sh  = q_data.err << FRAC_BITS;
  assign is_zero = (q_data.pwr == '0);
  assign is_sat  = !is_zero && (err_hi >= q_data.pwr);

  assign trial = {rem_r, quo_r[RATIO_W-1]};
  assign diff  = trial - {1'b0, pwr_r};
  assign ge    = !diff[SUM_W];

  assign q_pop = (state_r == S_IDLE) && !q_empty;

  always_comb begin
    state_nxt     = state_r;
    pwr_nxt       = pwr_r;
    rem_nxt       = rem_r;
    quo_nxt       = quo_r;
    step_nxt      = step_r;
    sat_nxt       = sat_r;
    zero_nxt      = zero_r;
    out_valid_nxt = out_valid_r && !out_pop;
    out_ratio_nxt = out_ratio_r;
    out_sat_nxt   = out_sat_r;
    out_zero_nxt  = out_zero_r;
    unique case (state_r)
      S_IDLE: begin
        if (!q_empty) begin
          pwr_nxt  = q_data.pwr;
          sat_nxt  = is_sat;
          zero_nxt = is_zero;
          step_nxt = '0;
          if (is_zero || is_sat) begin
            quo_nxt   = '1;
            state_nxt = S_HOLD;
          end else begin
            rem_nxt   = err_hi;
            quo_nxt   = err_sh[RATIO_W-1:0];
            state_nxt = S_RUN;
          end
        end
      end
      S_RUN: begin
        // one restoring step: shift in the next dividend bit, subtract if it fits
        rem_nxt  = ge ? diff[SUM_W-1:0] : trial[SUM_W-1:0];
        quo_nxt  = {quo_r[RATIO_W-2:0], ge};
        step_nxt = step_r + STEP_W'(1);
        if (step_r == STEP_W'(RATIO_W - 1)) begin
          state_nxt = S_HOLD;
        end
      end
      S_HOLD: begin
        if (!out_valid_r || out_pop) begin
          out_valid_nxt = 1'b1;
          out_ratio_nxt = quo_r;
          out_sat_nxt   = sat_r;
          out_zero_nxt  = zero_r;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    pwr_r       <= pwr_nxt;
    rem_r       <= rem_nxt;
    quo_r       <= quo_nxt;
    step_r      <= step_nxt;
    sat_r       <= sat_nxt;
    zero_r      <= zero_nxt;
    out_ratio_r <= out_ratio_nxt;
    out_sat_r   <= out_sat_nxt;
    out_zero_r  <= out_zero_nxt;
  end

  assign out_empty           = !out_valid_r;
  assign out_evm_ratio       = out_ratio_r;
  assign out_ratio_saturated = out_sat_r;
  assign out_zero_power      = out_zero_r;

  a_run_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_RUN) |-> (pwr_r != '0))
    else $error("divider running on zero power");

  a_flag_ratio: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_zero_r || out_sat_r)) |->
      ((out_ratio_r == '1) && !(out_zero_r && out_sat_r)))
    else $error("flagged result without clamped ratio");

endmodule
`default_nettype wire

// ----- rtl/core/evm_squared_meter_unit.sv -----
// Top level of the EVM squared meter: front accumulator, result queue, divider back end.
// Samples: one per cycle while in_full is low; an accepted sample passes s1 and s2 to the accumulators.
// Result: frame totals pass the s1 and s2 stages, the queue, the one-bit-per-cycle divider
// (skipped when saturated or zero power) and the result register; the divider pops a new frame only when idle.
// in_full rises only while two frame results are pending in the queue or on their way to it.
// Reset (synchronous, rst_n low) clears sums, position, queue, divider and result;
// registers return to cut_samples 0 and samples_per_mode 65535.
`default_nettype none
module evm_squared_meter_unit import esm_pkg::*; (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_we,
  input  wire logic [CFG_IDX_W-1:0]          cfg_idx,
  input  wire logic [CFG_W-1:0]              cfg_data,
  input  wire logic                          in_push,
  output logic                               in_full,
  input  wire logic signed [SAMPLE_BITS-1:0] in_ref_re,
  input  wire logic signed [SAMPLE_BITS-1:0] in_ref_im,
  input  wire logic signed [SAMPLE_BITS-1:0] in_rcv_re,
  input  wire logic signed [SAMPLE_BITS-1:0] in_rcv_im,
  input  wire logic                          in_frame_end,
  output logic                               out_empty,
  input  wire logic                          out_pop,
  output logic [RATIO_W-1:0]                 out_evm_ratio,
  output logic                               out_ratio_saturated,
  output logic                               out_zero_power
);

  logic              q_push, q_pop, q_empty;
  sums_t             q_din, q_dout;
  logic [QCNT_W-1:0] q_count;

  esm_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_idx      (cfg_idx),
    .cfg_data     (cfg_data),
    .in_push      (in_push),
    .in_full      (in_full),
    .in_ref_re    (in_ref_re),
    .in_ref_im    (in_ref_im),
    .in_rcv_re    (in_rcv_re),
    .in_rcv_im    (in_rcv_im),
    .in_frame_end (in_frame_end),
    .q_count      (q_count),
    .q_push       (q_push),
    .q_data       (q_din)
  );

  esm_fifo u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (q_din),
    .pop   (q_pop),
    .dout  (q_dout),
    .empty (q_empty),
    .count (q_count)
  );

  esm_back u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .q_empty             (q_empty),
    .q_data              (q_dout),
    .q_pop               (q_pop),
    .out_empty           (out_empty),
    .out_pop             (out_pop),
    .out_evm_ratio       (out_evm_ratio),
    .out_ratio_saturated (out_ratio_saturated),
    .out_zero_power      (out_zero_power)
  );

endmodule
`default_nettype wire

// ----- dv/evm_squared_meter_unit_tb.sv -----
// Self-checking testbench for the EVM squared meter: queued stimulus, predicted frame results.
module evm_squared_meter_unit_tb import esm_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 60;
  localparam int HOLD_CYCLES  = 300;
  localparam int MAX_GAP      = 11;

  typedef struct {
    logic signed [SAMPLE_BITS-1:0] ref_re, ref_im, rcv_re, rcv_im;
    logic                          frame_end;
  } meter_sample_t;

  typedef struct {
    logic [RATIO_W-1:0] ratio;
    logic               sat;
    logic               zero;
  } meter_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = REG_CUT;
  logic [CFG_W-1:0] cfg_data = '0;
  logic in_push = 1'b0;
  logic in_full;
  logic signed [SAMPLE_BITS-1:0] in_ref_re = '0;
  logic signed [SAMPLE_BITS-1:0] in_ref_im = '0;
  logic signed [SAMPLE_BITS-1:0] in_rcv_re = '0;
  logic signed [SAMPLE_BITS-1:0] in_rcv_im = '0;
  logic in_frame_end = 1'b0;
  logic out_empty;
  logic out_pop = 1'b0;
  logic [RATIO_W-1:0] out_evm_ratio;
  logic out_ratio_saturated;
  logic out_zero_power;

  evm_squared_meter_unit dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_idx             (cfg_idx),
    .cfg_data            (cfg_data),
    .in_push             (in_push),
    .in_full             (in_full),
    .in_ref_re           (in_ref_re),
    .in_ref_im           (in_ref_im),
    .in_rcv_re           (in_rcv_re),
    .in_rcv_im           (in_rcv_im),
    .in_frame_end        (in_frame_end),
    .out_empty           (out_empty),
    .out_pop             (out_pop),
    .out_evm_ratio       (out_evm_ratio),
    .out_ratio_saturated (out_ratio_saturated),
    .out_zero_power      (out_zero_power)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // mirrored configuration and accumulator state
  logic [CUT_W-1:0] cut_cfg = '0;
  logic [SPM_W-1:0] spm_cfg = '1;
  logic [SUM_W-1:0] err_acc = '0;
  logic [SUM_W-1:0] pwr_acc = '0;
  int unsigned      pos_cnt = 0;

  meter_sample_t pending_samples[$];
  meter_result_t expected_ratios[$];
  meter_sample_t cur_sample;
  meter_result_t want;

  int  mismatches = 0;
  int  cycle_count = 0;
  int  tx_gap = 0;
  int  rx_gap = 0;
  int  stall_left = 0;
  bit  tx_burst = 1'b0;
  bit  rx_burst = 1'b0;
  bit  press_req = 1'b0;
  bit  press_done = 1'b0;
  bit  offer_next;

  function automatic logic [SUM_W-1:0] sat_sum(logic [SUM_W-1:0] acc, longint unsigned term);
    longint unsigned total;
    total = longint'(acc) + term;
    return (total > longint'({SUM_W{1'b1}})) ? {SUM_W{1'b1}} : total[SUM_W-1:0];
  endfunction

  task automatic accumulate_sample(input meter_sample_t s);
    longint dre, dim, tre, tim;
    int unsigned span, nxt;
    logic [SUM_W+FRAC_BITS-1:0] scaled;
    meter_result_t r;
    tre = s.ref_re;
    tim = s.ref_im;
    dre = tre - longint'(s.rcv_re);
    dim = tim - longint'(s.rcv_im);
    span = (spm_cfg == 0) ? 65536 : spm_cfg;
    if (pos_cnt >= cut_cfg && pos_cnt + cut_cfg < span) begin
      err_acc = sat_sum(err_acc, dre * dre + dim * dim);
      pwr_acc = sat_sum(pwr_acc, tre * tre + tim * tim);
    end
    nxt = pos_cnt + 1;
    if (nxt >= span || nxt >= (1 << COUNT_BITS)) nxt = 0;
    pos_cnt = nxt;
    if (s.frame_end) begin
      r.sat = 1'b0;
      r.zero = 1'b0;
      if (pwr_acc == 0) begin
        r.ratio = '1;
        r.zero = 1'b1;
      end else if ((err_acc >> FRAC_BITS) >= pwr_acc) begin
        r.ratio = '1;
        r.sat = 1'b1;
      end else begin
        scaled = {err_acc, {FRAC_BITS{1'b0}}} / {{FRAC_BITS{1'b0}}, pwr_acc};
        r.ratio = scaled[RATIO_W-1:0];
      end
      expected_ratios.push_back(r);
      err_acc = '0;
      pwr_acc = '0;
      pos_cnt = 0;
    end
  endtask

  // driver: one beat per accepted sample
  always @(posedge clk) begin
    if (!rst_n) begin
      in_push <= 1'b0;
    end else begin
      if (in_push && !in_full) begin
        accumulate_sample(cur_sample);
        offer_next = 1'b1;
      end else begin
        offer_next = !in_push;
      end
      if (offer_next) begin
        if (tx_gap > 0) begin
          tx_gap--;
          in_push <= 1'b0;
        end else if (pending_samples.size() != 0) begin
          cur_sample = pending_samples.pop_front();
          in_ref_re <= cur_sample.ref_re;
          in_ref_im <= cur_sample.ref_im;
          in_rcv_re <= cur_sample.rcv_re;
          in_rcv_im <= cur_sample.rcv_im;
          in_frame_end <= cur_sample.frame_end;
          in_push <= 1'b1;
          tx_gap = tx_burst ? 0 : $urandom_range(0, MAX_GAP);
        end else begin
          in_push <= 1'b0;
        end
      end
    end
  end

  // monitor: check each result beat against the oldest prediction
  always @(posedge clk) begin
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else begin
      if (out_pop && !out_empty) begin
        if (expected_ratios.size() == 0) begin
          $display("%0t: unexpected result ratio=%h sat=%b zero=%b", $time,
                   out_evm_ratio, out_ratio_saturated, out_zero_power);
          mismatches++;
        end else begin
          want = expected_ratios.pop_front();
          if (out_evm_ratio !== want.ratio) begin
            $display("%0t: evm_ratio expected %h actual %h", $time, want.ratio, out_evm_ratio);
            mismatches++;
          end
          if (out_ratio_saturated !== want.sat) begin
            $display("%0t: ratio_saturated expected %b actual %b", $time, want.sat,
                     out_ratio_saturated);
            mismatches++;
          end
          if (out_zero_power !== want.zero) begin
            $display("%0t: zero_power expected %b actual %b", $time, want.zero, out_zero_power);
            mismatches++;
          end
        end
        rx_gap = rx_burst ? 0 : $urandom_range(0, MAX_GAP);
      end
      if (press_req && !press_done) begin
        stall_left = HOLD_CYCLES;
        press_done = 1'b1;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_pop <= 1'b0;
      end else if (rx_gap > 0) begin
        rx_gap--;
        out_pop <= 1'b0;
      end else begin
        out_pop <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic meter_sample_t mk(int tr, int ti, int rr, int ri, bit fe);
    meter_sample_t s;
    s.ref_re = SAMPLE_BITS'(tr);
    s.ref_im = SAMPLE_BITS'(ti);
    s.rcv_re = SAMPLE_BITS'(rr);
    s.rcv_im = SAMPLE_BITS'(ri);
    s.frame_end = fe;
    return s;
  endfunction

  function automatic logic signed [SAMPLE_BITS-1:0] corner_value();
    case ($urandom_range(0, 3))
      0: return -16'sd32768;
      1: return 16'sd32767;
      2: return 16'sd0;
      default: return -16'sd1;
    endcase
  endfunction

  function automatic meter_sample_t draw_sample();
    meter_sample_t s;
    int kind;
    int spread;
    kind = $urandom_range(0, 9);
    spread = 1 << $urandom_range(0, 12);
    s.ref_re = SAMPLE_BITS'($urandom);
    s.ref_im = SAMPLE_BITS'($urandom);
    s.rcv_re = SAMPLE_BITS'($urandom);
    s.rcv_im = SAMPLE_BITS'($urandom);
    if (kind < 6) begin
      // received close to reference: realistic small error
      s.rcv_re = s.ref_re + SAMPLE_BITS'($urandom_range(0, 2 * spread) - spread);
      s.rcv_im = s.ref_im + SAMPLE_BITS'($urandom_range(0, 2 * spread) - spread);
    end else if (kind == 8) begin
      s.ref_re = corner_value();
      s.ref_im = corner_value();
      s.rcv_re = corner_value();
      s.rcv_im = corner_value();
    end else if (kind == 9) begin
      // weak reference drives the ratio into saturation
      s.ref_re = SAMPLE_BITS'($urandom_range(0, 6) - 3);
      s.ref_im = SAMPLE_BITS'($urandom_range(0, 6) - 3);
    end
    s.frame_end = 1'b0;
    return s;
  endfunction

  task automatic queue_frame(int len);
    meter_sample_t s;
    for (int i = 0; i < len; i++) begin
      s = draw_sample();
      s.frame_end = (i == len - 1) || ($urandom_range(0, 19) == 0);
      pending_samples.push_back(s);
    end
  endtask

  task automatic wait_idle();
    @(negedge clk);
    while (pending_samples.size() != 0 || in_push || expected_ratios.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_cfg(cfg_reg_t idx, logic [CFG_W-1:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_CUT: cut_cfg = data[CUT_W-1:0];
      REG_SPM: spm_cfg = data[SPM_W-1:0];
      default: ;
    endcase
  endtask

  task automatic run_phase(int cut, int spm, int items, int max_len, bit tx_b, bit rx_b,
                           bit press);
    int n;
    wait_idle();
    // the spare top data bit rides along on cut writes and must be dropped
    write_cfg(REG_CUT, CFG_W'(cut) | (CFG_W'($urandom_range(0, 1)) << CUT_W));
    write_cfg(REG_SPM, CFG_W'(spm));
    @(negedge clk);
    tx_burst = tx_b;
    rx_burst = rx_b;
    if (press) press_req = 1'b1;
    n = 0;
    while (n < items) begin
      queue_frame($urandom_range(1, max_len));
      n += pending_samples.size() - n;
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    // zero reference power
    pending_samples.push_back(mk(0, 0, 32767, -32768, 1'b1));
    // full-scale opposite corners
    pending_samples.push_back(mk(-32768, -32768, 32767, 32767, 1'b0));
    pending_samples.push_back(mk(32767, 32767, -32768, -32768, 1'b1));
    // saturation, and the exact saturation boundary
    pending_samples.push_back(mk(1, 0, -32768, 32767, 1'b1));
    pending_samples.push_back(mk(1, 0, -255, 0, 1'b1));
    // just below the boundary
    pending_samples.push_back(mk(1, 0, -254, 0, 1'b1));
    // perfect match gives zero error
    pending_samples.push_back(mk(12345, -23456, 12345, -23456, 1'b1));
    pending_samples.push_back(mk(32767, -32768, -1, 0, 1'b0));
    pending_samples.push_back(mk(-1, -1, 0, 0, 1'b0));
    pending_samples.push_back(mk(100, -200, 101, -199, 1'b1));
    pending_samples.push_back(mk(-32768, 0, -32768, 1, 1'b1));
    pending_samples.push_back(mk(0, 0, 0, 0, 1'b0));
    pending_samples.push_back(mk(0, 0, 0, 0, 1'b1));
    // short modes with skipped edges and a wrap inside the frame
    run_phase(2, 5, 0, 1, 1'b0, 1'b0, 1'b0);
    for (int i = 0; i < 7; i++)
      pending_samples.push_back(mk(1000 + i, -500 * i, 990 + 2 * i, -500 * i + 7, i == 6));
    // large cut keeps nothing
    run_phase(5, 10, 0, 1, 1'b0, 1'b0, 1'b0);
    for (int i = 0; i < 4; i++)
      pending_samples.push_back(mk(3000, 4000, 0, 0, i == 3));

    run_phase(0, 1, 70, 12, 1'b0, 1'b0, 1'b0);
    run_phase(2, 8, 80, 20, 1'b0, 1'b1, 1'b0);
    run_phase(5, 10, 40, 15, 1'b1, 1'b0, 1'b0);
    run_phase(3, 0, 80, 20, 1'b0, 1'b0, 1'b0);
    run_phase(32767, 65535, 40, 10, 1'b0, 1'b0, 1'b0);
    // receiver holds off while short frames keep coming
    run_phase(1, 5, 100, 3, 1'b1, 1'b0, 1'b1);
    for (int p = 0; p < 3; p++)
      run_phase($urandom_range(0, 4), $urandom_range(1, 24), 60, 16,
                1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 1'b0);
    run_phase(0, 65535, 60, 25, 1'b0, 1'b0, 1'b0);
    wait_idle();
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
